// File: hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the segment/polygon clipper.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int MUL_W        = 27;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ACC_W        = 52;
    localparam int CHUNK_W      = 26;
    localparam int REM_W        = 76;
    localparam int QUO_W        = 25;
    localparam int CNT_W        = 7;
    localparam int MAX_VERT_DEF = 64;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CLIP = 1'b1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_RD0  = 12'b0000_0000_0010,
        S_GET0 = 12'b0000_0000_0100,
        S_RDN  = 12'b0000_0000_1000,
        S_GET  = 12'b0000_0001_0000,
        S_MUL  = 12'b0000_0010_0000,
        S_NORM = 12'b0000_0100_0000,
        S_CHK  = 12'b0000_1000_0000,
        S_PMUL = 12'b0001_0000_0000,
        S_DIV  = 12'b0010_0000_0000,
        S_FIX  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

endpackage

// File: hw/rtl/segment_polygon_clipper_unit.sv
// ----------------------------------------------------------------------------
// segment_polygon_clipper_unit
// Clips one segment against a stored closed polygon, reports two hits when it finds them.
// ----------------------------------------------------------------------------
// A load word writes one vertex. A clip word walks the polygon edges on one
// shared 27x27 multiplier: per edge one store read and six partial products;
// for each hit, each of its two coordinates takes partial products on the
// multiplier and a 25-step restoring divide. The walk stops after the second
// hit, which loads the output register; with fewer hits no result is given.
// The input is not ready while a clip is in progress; a finished result waits
// in the output register.
module segment_polygon_clipper_unit #(
    parameter int MAX_VERTICES = spc_pkg::MAX_VERT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spc_pkg::CNT_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_opcode,
    input  logic [5:0]                         i_vertex_index,
    input  logic signed [spc_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [spc_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [spc_pkg::COORD_W-1:0] i_seg_start_x,
    input  logic signed [spc_pkg::COORD_W-1:0] i_seg_start_y,
    input  logic signed [spc_pkg::COORD_W-1:0] i_seg_end_x,
    input  logic signed [spc_pkg::COORD_W-1:0] i_seg_end_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [spc_pkg::COORD_W-1:0] o_low_x,
    output logic signed [spc_pkg::COORD_W-1:0] o_low_y,
    output logic signed [spc_pkg::COORD_W-1:0] o_high_x,
    output logic signed [spc_pkg::COORD_W-1:0] o_high_y
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int IW = (AW > 6) ? AW : 6;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CRD = spc_pkg::COORD_W;
    localparam int DW = spc_pkg::DIFF_W;
    localparam int MW = spc_pkg::MUL_W;
    localparam int PW = spc_pkg::PROD_W;
    localparam int AC = spc_pkg::ACC_W;
    localparam int CK = spc_pkg::CHUNK_W;
    localparam int RW = spc_pkg::REM_W;
    localparam int QW = spc_pkg::QUO_W;

    logic [2*CRD-1:0] r_mem [MAX_VERTICES];
    logic [2*CRD-1:0] r_rd;
    logic [AW-1:0]    rd_addr;

    spc_pkg::t_state r_state, n_state;

    logic [spc_pkg::CNT_W-1:0] r_count;
    logic signed [CRD-1:0] r_sx, r_sy;
    logic signed [DW-1:0]  r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [CRD-1:0] r_q1x, r_q1y;
    logic [CW-1:0]         r_n, r_i;
    logic [4:0]            r_step;
    logic signed [PW-1:0]  r_prod;
    logic signed [AC-1:0]  r_den, r_na, r_nb;
    logic                  r_sel, r_hits;
    logic [RW-1:0]         r_rem, r_dsh;
    logic [QW-1:0]         r_q;
    logic signed [CRD-1:0] r_hx, r_hy, r_fx, r_fy;
    logic                  r_out_valid;
    logic signed [CRD-1:0] r_lx, r_ly, r_gx, r_gy;

    logic [IW-1:0]         w_idx;
    logic [CW-1:0]         n_eff, i_next;
    logic                  last_edge;
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [AC-1:0]  prod_s;
    logic signed [DW-1:0]  d_sel;
    logic [DW-1:0]         mag;
    logic signed [CRD-1:0] p_sel;
    logic                  frac, d_neg;
    logic signed [CRD+2:0] f_val, base;
    logic signed [CRD-1:0] fix_val;
    logic                  in_acc, no_hit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == spc_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_low_x     = r_lx;
    assign o_low_y     = r_ly;
    assign o_high_x    = r_gx;
    assign o_high_y    = r_gy;

    assign w_idx     = IW'(i_vertex_index);
    assign n_eff     = (int'(r_count) >= MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_count);
    assign i_next    = r_i + CW'(1);
    assign last_edge = (i_next == r_n);
    assign rd_addr   = (r_state == spc_pkg::S_RD0 || last_edge) ? '0 : i_next[AW-1:0];

    // vertex store
    always_ff @(posedge i_clk) begin
        if (in_acc && i_opcode == spc_pkg::OP_LOAD && int'(i_vertex_index) < MAX_VERTICES) begin
            r_mem[w_idx[AW-1:0]] <= {i_vertex_x, i_vertex_y};
        end
        r_rd <= r_mem[rd_addr];
    end

    // shared multiplier operand select
    assign d_sel = r_sel ? r_ay : r_ax;
    assign p_sel = r_sel ? r_sy : r_sx;
    assign d_neg = d_sel[DW-1];
    assign mag   = d_neg ? DW'(-d_sel) : DW'(d_sel);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == spc_pkg::S_PMUL) begin
            mul_a = MW'({1'b0, mag});
            mul_b = (r_step == 5'd0) ? MW'({1'b0, r_na[CK-1:0]})
                                     : MW'({1'b0, r_na[AC-1:CK]});
        end else begin
            case (r_step)
                5'd0: begin mul_a = MW'(r_ay); mul_b = MW'(r_bx); end
                5'd1: begin mul_a = MW'(r_ax); mul_b = MW'(r_by); end
                5'd2: begin mul_a = MW'(r_by); mul_b = MW'(r_cx); end
                5'd3: begin mul_a = MW'(r_bx); mul_b = MW'(r_cy); end
                5'd4: begin mul_a = MW'(r_ax); mul_b = MW'(r_cy); end
                5'd5: begin mul_a = MW'(r_ay); mul_b = MW'(r_cx); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign prod_s = r_prod[AC-1:0];

    // truncation toward zero of p + d*num/den
    assign frac  = |r_rem;
    assign f_val = d_neg ? -$signed({2'b00, r_q}) - $signed((CRD+3)'(frac))
                         : $signed({2'b00, r_q});
    always_comb begin
        base = $signed((CRD+3)'(p_sel)) + f_val;
        if (frac && base < 0) begin
            base = base + (CRD+3)'(1);
        end
    end
    assign fix_val = base[CRD-1:0];

    assign no_hit = (r_na < 0) || (r_na > r_den) || (r_nb < 0) || (r_nb > r_den);

    always_comb begin
        n_state = r_state;
        case (r_state)
            spc_pkg::S_IDLE: begin
                if (in_acc && i_opcode == spc_pkg::OP_CLIP && n_eff != '0) begin
                    n_state = spc_pkg::S_RD0;
                end
            end
            spc_pkg::S_RD0:  n_state = spc_pkg::S_GET0;
            spc_pkg::S_GET0: n_state = spc_pkg::S_RDN;
            spc_pkg::S_RDN:  n_state = spc_pkg::S_GET;
            spc_pkg::S_GET:  n_state = spc_pkg::S_MUL;
            spc_pkg::S_MUL: begin
                if (r_step == 5'd6) begin
                    n_state = spc_pkg::S_NORM;
                end
            end
            spc_pkg::S_NORM: begin
                if (r_den == '0) begin
                    n_state = last_edge ? spc_pkg::S_IDLE : spc_pkg::S_RDN;
                end else begin
                    n_state = spc_pkg::S_CHK;
                end
            end
            spc_pkg::S_CHK: begin
                if (no_hit) begin
                    n_state = last_edge ? spc_pkg::S_IDLE : spc_pkg::S_RDN;
                end else begin
                    n_state = spc_pkg::S_PMUL;
                end
            end
            spc_pkg::S_PMUL: begin
                if (r_step == 5'd2) begin
                    n_state = spc_pkg::S_DIV;
                end
            end
            spc_pkg::S_DIV: begin
                if (r_step == 5'(QW - 1)) begin
                    n_state = spc_pkg::S_FIX;
                end
            end
            spc_pkg::S_FIX: begin
                if (!r_sel) begin
                    n_state = spc_pkg::S_PMUL;
                end else if (r_hits) begin
                    n_state = spc_pkg::S_OUT;
                end else begin
                    n_state = last_edge ? spc_pkg::S_IDLE : spc_pkg::S_RDN;
                end
            end
            spc_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = spc_pkg::S_IDLE;
                end
            end
            default: n_state = spc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spc_pkg::S_IDLE;
            r_count     <= spc_pkg::CNT_W'(3);
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_i         <= '0;
            r_hits      <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (r_state == spc_pkg::S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_prod <= mul_p;
            case (r_state)
                spc_pkg::S_IDLE: begin
                    r_sx   <= i_seg_start_x;
                    r_sy   <= i_seg_start_y;
                    r_ax   <= DW'(i_seg_end_x) - DW'(i_seg_start_x);
                    r_ay   <= DW'(i_seg_end_y) - DW'(i_seg_start_y);
                    r_n    <= n_eff;
                    r_i    <= '0;
                    r_hits <= 1'b0;
                end
                spc_pkg::S_GET0: begin
                    r_q1x <= r_rd[2*CRD-1:CRD];
                    r_q1y <= r_rd[CRD-1:0];
                end
                spc_pkg::S_GET: begin
                    r_bx   <= DW'(r_q1x) - DW'($signed(r_rd[2*CRD-1:CRD]));
                    r_by   <= DW'(r_q1y) - DW'($signed(r_rd[CRD-1:0]));
                    r_cx   <= DW'(r_sx) - DW'(r_q1x);
                    r_cy   <= DW'(r_sy) - DW'(r_q1y);
                    r_q1x  <= r_rd[2*CRD-1:CRD];
                    r_q1y  <= r_rd[CRD-1:0];
                    r_step <= '0;
                end
                spc_pkg::S_MUL: begin
                    r_step <= r_step + 5'd1;
                    case (r_step)
                        5'd1: r_den <= prod_s;
                        5'd2: r_den <= r_den - prod_s;
                        5'd3: r_na  <= prod_s;
                        5'd4: r_na  <= r_na - prod_s;
                        5'd5: r_nb  <= prod_s;
                        5'd6: r_nb  <= r_nb - prod_s;
                        default: ;
                    endcase
                end
                spc_pkg::S_NORM: begin
                    if (r_den < 0) begin
                        r_den <= -r_den;
                        r_na  <= -r_na;
                        r_nb  <= -r_nb;
                    end
                    if (r_den == '0) begin
                        r_i <= i_next;
                    end
                end
                spc_pkg::S_CHK: begin
                    r_sel  <= 1'b0;
                    r_step <= '0;
                    if (no_hit) begin
                        r_i <= i_next;
                    end
                end
                spc_pkg::S_PMUL: begin
                    r_step <= (r_step == 5'd2) ? 5'd0 : r_step + 5'd1;
                    if (r_step == 5'd1) begin
                        r_rem <= RW'(prod_s);
                    end
                    if (r_step == 5'd2) begin
                        r_rem  <= r_rem + (RW'(prod_s) << CK);
                        r_dsh  <= RW'(r_den) << (QW - 1);
                        r_q    <= '0;
                    end
                end
                spc_pkg::S_DIV: begin
                    r_step <= r_step + 5'd1;
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                end
                spc_pkg::S_FIX: begin
                    r_step <= '0;
                    if (!r_sel) begin
                        r_hx  <= fix_val;
                        r_sel <= 1'b1;
                    end else begin
                        r_hy <= fix_val;
                        if (!r_hits) begin
                            r_fx   <= r_hx;
                            r_fy   <= fix_val;
                            r_hits <= 1'b1;
                            r_i    <= i_next;
                        end
                    end
                end
                spc_pkg::S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        if (r_fy < r_hy) begin
                            r_lx <= r_fx; r_ly <= r_fy; r_gx <= r_hx; r_gy <= r_hy;
                        end else begin
                            r_lx <= r_hx; r_ly <= r_hy; r_gx <= r_fx; r_gy <= r_fy;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/spc_checker.sv
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks of the segment/polygon clipper, bound to the top level.
// ----------------------------------------------------------------------------
module spc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_opcode,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [spc_pkg::COORD_W-1:0] o_low_y,
    input logic signed [spc_pkg::COORD_W-1:0] o_high_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_low_y <= o_high_y))
        else $error("hits out of y order");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode == spc_pkg::OP_LOAD) |=> o_in_ready)
        else $error("load word stalled input");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode == spc_pkg::OP_LOAD && !o_out_valid)
        |=> !o_out_valid)
        else $error("load word produced a result");

endmodule

bind segment_polygon_clipper_unit spc_checker u_spc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_opcode    (i_opcode),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_low_y     (o_low_y),
    .o_high_y    (o_high_y)
);
